[rtl/swsfr_pkg.sv]
// Shared types and constants of the sliding-window sender with fast retransmit.
// No dependencies; used by swsfr_classify and the top level.
package swsfr_pkg;

    // Operation codes of the input item
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Timer commands
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    localparam logic signed [3:0] ACK_NONE      = -4'sd1;
    localparam logic [2:0]        COUNTER_MAX   = 3'd7;
    localparam logic [2:0]        THRESH_RESET  = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [63:0]        message_data;
        logic signed [3:0]  ack_number;
        logic               ack_intact;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        transmit;
        logic [2:0]  packet_seq;
        logic [63:0] packet_data;
        logic [1:0]  timer_command;
        logic        window_full;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_WALK
    } t_state;

    typedef enum logic [2:0] {
        ACT_EMPTY,
        ACT_FULL,
        ACT_SEND,
        ACT_SLIDE,
        ACT_RESEND,
        ACT_TIMEOUT
    } t_act;

    typedef struct packed {
        t_act       act;
        logic       cnt_we;
        logic [2:0] cnt_val;
    } t_dec;

endpackage

[rtl/swsfr_classify.sv]
// Decides what one input item does against the current window state.
// Depends on swsfr_pkg.
module swsfr_classify #(
    parameter int WINDOW_SIZE = 4,
    parameter int SEQ_SPACE   = 8
) (
    input  swsfr_pkg::t_in_item               i_item,
    input  logic [$clog2(SEQ_SPACE)-1:0]      i_base,
    input  logic [$clog2(WINDOW_SIZE+1)-1:0]  i_count,
    input  logic [2:0]                        i_cnt_old,
    input  logic [2:0]                        i_thr,
    output swsfr_pkg::t_dec                   o_dec,
    output logic [$clog2(WINDOW_SIZE+1)-1:0]  o_freed
);

    localparam int SW   = $clog2(SEQ_SPACE);
    localparam int CNTW = $clog2(WINDOW_SIZE + 1);
    localparam int OW   = ((SW + 1) > CNTW) ? (SW + 1) : CNTW;

    logic [SW:0]  a_x;
    logic [SW:0]  base_x;
    logic [SW:0]  offset;
    logic         ack_ok;
    logic         in_win;
    logic         busy;
    logic [2:0]   cnt_new;

    always_comb begin
        a_x     = (SW + 1)'(i_item.ack_number[2:0]);
        base_x  = (SW + 1)'(i_base);
        // distance from the window base, modulo the sequence space
        if (a_x >= base_x) begin
            offset = a_x - base_x;
        end else begin
            offset = a_x + (SW + 1)'(SEQ_SPACE) - base_x;
        end
        in_win  = OW'(offset) < OW'(i_count);
        o_freed = CNTW'(offset + (SW + 1)'(1));
        busy    = (i_count != '0);
        ack_ok  = i_item.ack_intact &&
                  ((i_item.ack_number == swsfr_pkg::ACK_NONE) ||
                   (!i_item.ack_number[3] && (32'(i_item.ack_number[2:0]) < SEQ_SPACE)));
        cnt_new = (i_cnt_old < swsfr_pkg::COUNTER_MAX) ? i_cnt_old + 3'd1
                                                       : swsfr_pkg::COUNTER_MAX;

        o_dec.act     = swsfr_pkg::ACT_EMPTY;
        o_dec.cnt_we  = 1'b0;
        o_dec.cnt_val = cnt_new;
        case (i_item.operation)
            swsfr_pkg::OP_SEND: begin
                o_dec.act = (32'(i_count) >= WINDOW_SIZE) ? swsfr_pkg::ACT_FULL
                                                          : swsfr_pkg::ACT_SEND;
            end
            swsfr_pkg::OP_ACK: begin
                if (!ack_ok) begin
                    o_dec.act = swsfr_pkg::ACT_EMPTY;
                end else if (i_item.ack_number == swsfr_pkg::ACK_NONE) begin
                    o_dec.act = busy ? swsfr_pkg::ACT_RESEND : swsfr_pkg::ACT_EMPTY;
                end else if (in_win) begin
                    o_dec.act     = swsfr_pkg::ACT_SLIDE;
                    o_dec.cnt_we  = 1'b1;
                    o_dec.cnt_val = 3'd1;
                end else begin
                    o_dec.cnt_we = 1'b1;
                    if ((cnt_new == i_thr) && busy) begin
                        o_dec.act     = swsfr_pkg::ACT_RESEND;
                        o_dec.cnt_val = 3'd0;
                    end
                end
            end
            swsfr_pkg::OP_TIMEOUT: begin
                o_dec.act = swsfr_pkg::ACT_TIMEOUT;
            end
            default: begin
                o_dec.act = swsfr_pkg::ACT_EMPTY;
            end
        endcase
    end

endmodule

[rtl/sliding_window_sender_fast_retransmit.sv]
// Top level of the go-back-N sender with fast retransmit and duplicate-ack counting.
// Depends on swsfr_pkg and swsfr_classify.

// A send, an acknowledgement or an unused operation passes through the transfer
// cycle, in which the payload ring and the duplicate-ack counter table are read
// at the window head and at the acked number, and then through S_PROC, in which
// the result is formed and the state written back. In a timeout, S_PROC and then
// S_WALK resend the outstanding packets, read from the payload ring one entry per
// cycle through its single read port while the output register is free. A new
// input item is taken only once every result of the previous one sits in the
// output register; that register lets the next item enter while the last result
// still waits. An output stall holds the item in its current state. The counter
// table is valid right after reset: each entry carries a valid bit that reset
// clears. The threshold register is written through i_cfg_we/i_cfg_data; the
// user writes it only while the block is idle, which the block does not check.
module sliding_window_sender_fast_retransmit #(
    parameter int WINDOW_SIZE  = 4,
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  swsfr_pkg::t_in_item  i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output swsfr_pkg::t_out_item o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_data
);

    localparam int SW   = $clog2(SEQ_SPACE);
    localparam int CNTW = $clog2(WINDOW_SIZE + 1);
    localparam int HW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    // window state
    logic [SW-1:0]   r_base, n_base;
    logic [SW-1:0]   r_nseq, n_nseq;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_wait, n_wait;
    logic [HW-1:0]   r_head, n_head;
    logic [2:0]      r_thr;

    // item in flight and timeout walk
    swsfr_pkg::t_state   r_state, n_state;
    swsfr_pkg::t_in_item r_item;
    logic [HW-1:0]       r_slot, n_slot;
    logic [SW-1:0]       r_cidx, n_cidx;
    logic [CNTW-1:0]     r_walk_i, n_walk_i;
    logic [SW-1:0]       r_walk_seq, n_walk_seq;

    // memories: payload ring (oldest packet at r_head) and dup-ack counters
    logic [PAYLOAD_BITS-1:0] r_ring [WINDOW_SIZE];
    logic [PAYLOAD_BITS-1:0] r_pl_rdata;
    logic [2:0]              r_cnt_mem [SEQ_SPACE];
    logic [2:0]              r_cnt_rdata;
    logic [SEQ_SPACE-1:0]    r_cnt_vld;

    // output register
    logic                 r_out_valid;
    swsfr_pkg::t_out_item r_out, n_out;

    logic            out_free;
    logic            emit;
    logic            ring_we;
    logic [HW-1:0]   ring_waddr;
    logic            cnt_we;
    logic [2:0]      cnt_old;
    logic            walk_last;
    logic [SW-1:0]   ack_idx;
    swsfr_pkg::t_dec dec;
    logic [CNTW-1:0] freed;

    function automatic logic [HW-1:0] slot_add(input logic [HW-1:0] s,
                                               input logic [CNTW-1:0] k);
        logic [CNTW:0] sum;
        sum = (CNTW + 1)'(s) + (CNTW + 1)'(k);
        if (32'(sum) >= WINDOW_SIZE) begin
            sum = sum - (CNTW + 1)'(WINDOW_SIZE);
        end
        return HW'(sum);
    endfunction

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
        return (32'(s) == SEQ_SPACE - 1) ? '0 : s + SW'(1);
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == swsfr_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;
    assign cnt_old  = r_cnt_vld[r_cidx] ? r_cnt_rdata : 3'd0;
    assign ack_idx  = SW'(r_item.ack_number[2:0]);
    assign walk_last = ((CNTW + 1)'(r_walk_i) + (CNTW + 1)'(1)) == (CNTW + 1)'(r_count);

    swsfr_classify #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SEQ_SPACE   (SEQ_SPACE)
    ) u_classify (
        .i_item    (r_item),
        .i_base    (r_base),
        .i_count   (r_count),
        .i_cnt_old (cnt_old),
        .i_thr     (r_thr),
        .o_dec     (dec),
        .o_freed   (freed)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swsfr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = swsfr_pkg::S_PROC;
                end
            end
            swsfr_pkg::S_PROC: begin
                if (out_free) begin
                    if ((dec.act == swsfr_pkg::ACT_TIMEOUT) &&
                        (32'(r_count) > 1)) begin
                        n_state = swsfr_pkg::S_WALK;
                    end else begin
                        n_state = swsfr_pkg::S_IDLE;
                    end
                end
            end
            swsfr_pkg::S_WALK: begin
                if (out_free && walk_last) begin
                    n_state = swsfr_pkg::S_IDLE;
                end
            end
            default: n_state = swsfr_pkg::S_IDLE;
        endcase
    end

    // Datapath and result forming
    always_comb begin
        n_base     = r_base;
        n_nseq     = r_nseq;
        n_count    = r_count;
        n_wait     = r_wait;
        n_head     = r_head;
        n_slot     = r_slot;
        n_cidx     = r_cidx;
        n_walk_i   = r_walk_i;
        n_walk_seq = r_walk_seq;
        emit       = 1'b0;
        ring_we    = 1'b0;
        ring_waddr = slot_add(r_head, r_count);
        cnt_we     = 1'b0;

        n_out               = '0;
        n_out.window_full   = r_wait;
        n_out.last          = 1'b1;

        unique case (r_state)
            swsfr_pkg::S_IDLE: begin
                // keep the head entry and the acked counter on the read ports
                n_slot = r_head;
                n_cidx = SW'(i_in.ack_number[2:0]);
            end
            swsfr_pkg::S_PROC: begin
                emit   = out_free;
                cnt_we = out_free && dec.cnt_we;
                case (dec.act)
                    swsfr_pkg::ACT_SEND: begin
                        ring_we              = out_free;
                        n_count              = r_count + CNTW'(1);
                        n_nseq               = seq_inc(r_nseq);
                        n_wait               = (32'(r_count) + 1 >= WINDOW_SIZE);
                        n_out.accepted       = 1'b1;
                        n_out.transmit       = 1'b1;
                        n_out.packet_seq     = 3'(r_nseq);
                        n_out.packet_data    = 64'(r_item.message_data[PAYLOAD_BITS-1:0]);
                        n_out.timer_command  = (r_count == '0) ? swsfr_pkg::TMR_START
                                                               : swsfr_pkg::TMR_NONE;
                        n_out.window_full    = n_wait;
                    end
                    swsfr_pkg::ACT_SLIDE: begin
                        // drop every packet up to and including the acked one
                        n_count             = r_count - freed;
                        n_base              = seq_inc(ack_idx);
                        n_head              = slot_add(r_head, freed);
                        n_wait              = 1'b0;
                        n_out.timer_command = (n_count == '0) ? swsfr_pkg::TMR_STOP
                                                              : swsfr_pkg::TMR_RESTART;
                        n_out.window_full   = 1'b0;
                    end
                    swsfr_pkg::ACT_RESEND: begin
                        n_out.transmit    = 1'b1;
                        n_out.packet_seq  = 3'(r_base);
                        n_out.packet_data = 64'(r_pl_rdata);
                    end
                    swsfr_pkg::ACT_TIMEOUT: begin
                        n_out.timer_command = swsfr_pkg::TMR_RESTART;
                        if (r_count != '0) begin
                            n_out.transmit    = 1'b1;
                            n_out.packet_seq  = 3'(r_base);
                            n_out.packet_data = 64'(r_pl_rdata);
                            n_out.last        = (32'(r_count) == 1);
                            if (out_free) begin
                                // advance the read port to the next outstanding packet
                                n_slot     = slot_add(r_slot, CNTW'(1));
                                n_walk_i   = CNTW'(1);
                                n_walk_seq = seq_inc(r_base);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // hold the window until the output register takes the result
                if (!out_free) begin
                    n_base  = r_base;
                    n_nseq  = r_nseq;
                    n_count = r_count;
                    n_wait  = r_wait;
                    n_head  = r_head;
                end
            end
            swsfr_pkg::S_WALK: begin
                emit              = out_free;
                n_out.transmit    = 1'b1;
                n_out.packet_seq  = 3'(r_walk_seq);
                n_out.packet_data = 64'(r_pl_rdata);
                n_out.last        = walk_last;
                if (out_free) begin
                    n_slot     = slot_add(r_slot, CNTW'(1));
                    n_walk_i   = r_walk_i + CNTW'(1);
                    n_walk_seq = seq_inc(r_walk_seq);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swsfr_pkg::S_IDLE;
            r_base      <= SW'(1);
            r_nseq      <= SW'(1);
            r_count     <= '0;
            r_wait      <= 1'b0;
            r_head      <= '0;
            r_thr       <= swsfr_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
            r_cnt_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_nseq  <= n_nseq;
            r_count <= n_count;
            r_wait  <= n_wait;
            r_head  <= n_head;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cnt_we) begin
                r_cnt_vld[r_cidx] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_cidx     <= n_cidx;
        r_walk_i   <= n_walk_i;
        r_walk_seq <= n_walk_seq;
        if (i_valid && o_ready) begin
            r_item <= i_in;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Payload ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= r_item.message_data[PAYLOAD_BITS-1:0];
        end
        r_pl_rdata <= r_ring[n_slot];
    end

    // Duplicate-ack counter table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_cidx] <= dec.cnt_val;
        end
        r_cnt_rdata <= r_cnt_mem[n_cidx];
    end

    // The window never holds more packets than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= WINDOW_SIZE)
        else $error("outstanding count above window size");

    // The waiting flag tracks a full window exactly
    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait == (32'(r_count) == WINDOW_SIZE))
        else $error("window_full flag out of step with count");

    // A result that is not the last of its item only comes from a timeout walk
    a_nonlast_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == swsfr_pkg::S_WALK))
        else $error("non-final result outside timeout walk");

    // Nothing is taken in while a timeout walk is still running
    a_walk_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swsfr_pkg::S_WALK) |=> (r_state != swsfr_pkg::S_PROC))
        else $error("new item started during timeout walk");

endmodule
